[hdl/mtat_pkg.sv]
package mtat_pkg;

  // fixed field and register widths
  localparam int RAW_W     = 16;
  localparam int POS_W     = 32;
  localparam int TCNT_W    = 16;
  localparam int RANGE_W   = 17;
  localparam int LIMIT_W   = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 17;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

  // divide by three: floor(x / 3) == (x * RECIP3) >> RECIP_SHIFT for x below 2**17
  localparam int RECIP_SHIFT = 18;
  localparam logic [RANGE_W-1:0] RECIP3 = RANGE_W'(87382);
  localparam int PROD3_W = 2 * RANGE_W;
  localparam int DIV_W   = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_RANGE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_LIMIT   = 2'd2;

  // reset values
  localparam logic [RANGE_W-1:0] TURN_RANGE_RST = 17'd8192;
  localparam logic [LIMIT_W-1:0] TURN_LIMIT_RST = 15'd1;

  // sector classes; sector three leaves the turn count and last sector unchanged
  typedef enum logic [1:0] {
    SEC_0    = 2'd0,
    SEC_1    = 2'd1,
    SEC_2    = 2'd2,
    SEC_NONE = 2'd3
  } sector_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_angle;
    logic calc_div;
    logic calc_sector;
    logic update_count;
    logic calc_pos;
    logic load_out;
  } cmd_t;

endpackage

[hdl/mtat_dp.sv]
module mtat_dp #(
  parameter int ANGLE_BITS = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mtat_pkg::cmd_t                    cmd,
  input  logic [mtat_pkg::IN_DATA_W-1:0]    raw_angle,
  input  logic                              cfg_we,
  input  logic [mtat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mtat_pkg::CFG_W-1:0]        cfg_wdata,
  output logic [mtat_pkg::POS_W-1:0]        total_position,
  output logic [mtat_pkg::TCNT_W-1:0]       turn_count
);

  localparam int AW = (ANGLE_BITS < mtat_pkg::RAW_W) ? ANGLE_BITS : mtat_pkg::RAW_W;
  localparam int EW = ((COUNT_BITS > mtat_pkg::TCNT_W) ? COUNT_BITS : mtat_pkg::TCNT_W) + 1;
  localparam int PW = COUNT_BITS + mtat_pkg::RANGE_W + 1;
  localparam int XW = 48;
  localparam int MW = mtat_pkg::DIV_W + 2;
  localparam logic signed [EW-1:0] CNT_HI = EW'((64'sd1 <<< (COUNT_BITS - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] CNT_LO = -CNT_HI - EW'(1);

  // configuration registers
  logic [mtat_pkg::RANGE_W-1:0] turn_range_r;
  logic                         limit_enable_r;
  logic [mtat_pkg::LIMIT_W-1:0] turn_limit_r;

  // tracker state
  logic signed [COUNT_BITS-1:0] turn_counter_r;
  logic signed [COUNT_BITS-1:0] turn_counter_nxt;
  mtat_pkg::sector_t            last_sector_r;
  mtat_pkg::sector_t            last_sector_nxt;

  // per-word working registers
  logic [AW-1:0]                   angle_r;
  logic [mtat_pkg::PROD3_W-1:0]    prod3_r;
  logic [mtat_pkg::DIV_W-1:0]      div_r;
  mtat_pkg::sector_t               sector_r;
  mtat_pkg::sector_t               sector_nxt;
  logic signed [PW-1:0]            mult_r;
  logic [mtat_pkg::POS_W-1:0]      pos_r;
  logic [mtat_pkg::TCNT_W-1:0]     tcnt_r;

  logic [MW-1:0]           d1, d2, d4, ang_ext;
  logic signed [EW-1:0]    cnt_step, cnt_wrap, cnt_clamp, lim_ext;
  logic signed [XW-1:0]    mult_x;
  logic signed [mtat_pkg::POS_W-1:0] cnt_x;

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_range_r   <= mtat_pkg::TURN_RANGE_RST;
      limit_enable_r <= 1'b0;
      turn_limit_r   <= mtat_pkg::TURN_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtat_pkg::CFG_TURN_RANGE:   turn_range_r   <= cfg_wdata[mtat_pkg::RANGE_W-1:0];
        mtat_pkg::CFG_LIMIT_ENABLE: limit_enable_r <= cfg_wdata[0];
        mtat_pkg::CFG_TURN_LIMIT:   turn_limit_r   <= cfg_wdata[mtat_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // sector bounds: one, two and four sector widths
  always_comb begin
    d1      = MW'(div_r);
    d2      = MW'({div_r, 1'b0});
    d4      = MW'({div_r, 2'b00});
    ang_ext = MW'(angle_r);
    priority if (ang_ext < d1) sector_nxt = mtat_pkg::SEC_0;
    else if (ang_ext < d2)     sector_nxt = mtat_pkg::SEC_1;
    else if (ang_ext < d4)     sector_nxt = mtat_pkg::SEC_2;
    else                       sector_nxt = mtat_pkg::SEC_NONE;
  end

  // turn update, limited-mode wrap, saturation
  always_comb begin
    cnt_step        = EW'(turn_counter_r);
    last_sector_nxt = last_sector_r;
    unique case (sector_r)
      mtat_pkg::SEC_0: begin
        if (last_sector_r == mtat_pkg::SEC_2) cnt_step = cnt_step + EW'(1);
        last_sector_nxt = mtat_pkg::SEC_0;
      end
      mtat_pkg::SEC_1: last_sector_nxt = mtat_pkg::SEC_1;
      mtat_pkg::SEC_2: begin
        if (last_sector_r == mtat_pkg::SEC_0) cnt_step = cnt_step - EW'(1);
        last_sector_nxt = mtat_pkg::SEC_2;
      end
      default: ;
    endcase
    lim_ext  = signed'(EW'(turn_limit_r));
    cnt_wrap = cnt_step;
    if (limit_enable_r) begin
      if (cnt_wrap >= lim_ext) cnt_wrap = '0;
      if (cnt_wrap < 0)        cnt_wrap = lim_ext - EW'(1);
    end
    priority if (cnt_wrap > CNT_HI) cnt_clamp = CNT_HI;
    else if (cnt_wrap < CNT_LO)     cnt_clamp = CNT_LO;
    else                            cnt_clamp = cnt_wrap;
    turn_counter_nxt = cnt_clamp[COUNT_BITS-1:0];
  end

  // tracker state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_counter_r <= '0;
      last_sector_r  <= mtat_pkg::SEC_0;
    end else if (cmd.update_count) begin
      turn_counter_r <= turn_counter_nxt;
      last_sector_r  <= last_sector_nxt;
    end
  end

  assign mult_x = XW'(mult_r);
  assign cnt_x  = mtat_pkg::POS_W'(turn_counter_r);

  // datapath pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.load_angle) begin
      angle_r <= raw_angle[AW-1:0];
      prod3_r <= turn_range_r * mtat_pkg::RECIP3;
    end
    if (cmd.calc_div) begin
      div_r <= prod3_r[mtat_pkg::RECIP_SHIFT +: mtat_pkg::DIV_W];
    end
    if (cmd.calc_sector) begin
      sector_r <= sector_nxt;
    end
    if (cmd.calc_pos) begin
      mult_r <= turn_counter_r * signed'({1'b0, turn_range_r});
    end
    if (cmd.load_out) begin
      pos_r  <= mult_x[mtat_pkg::POS_W-1:0] + mtat_pkg::POS_W'(angle_r);
      tcnt_r <= cnt_x[mtat_pkg::TCNT_W-1:0];
    end
  end

  assign total_position = pos_r;
  assign turn_count     = tcnt_r;

endmodule

[hdl/mtat_ctrl.sv]
module mtat_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output mtat_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SECT,
    S_CNT,
    S_POS,
    S_DONE
  } state_t;

  state_t state_r;
  logic   out_tvalid_r;
  logic   out_free;

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // commands decoded from state
  always_comb begin
    cmd              = '0;
    cmd.load_angle   = (state_r == S_IDLE) && in_tvalid;
    cmd.calc_div     = (state_r == S_DIV);
    cmd.calc_sector  = (state_r == S_SECT);
    cmd.update_count = (state_r == S_CNT);
    cmd.calc_pos     = (state_r == S_POS);
    cmd.load_out     = (state_r == S_DONE) && out_free;
  end

  // sequencer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.load_out)    out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid) state_r <= S_DIV;
        S_DIV:  state_r <= S_SECT;
        S_SECT: state_r <= S_CNT;
        S_CNT:  state_r <= S_POS;
        S_POS:  state_r <= S_DONE;
        S_DONE: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;

endmodule

[hdl/multi_turn_angle_tracker.sv]
// channel | direction | handshake          | payload
// in_     | slave     | in_tvalid/tready   | in_tdata[15:0] raw_angle
// out_    | master    | out_tvalid/tready  | out_tdata[31:0] total_position,
//         |           |                    | out_tdata[47:32] turn_count
// cfg_    | write     | cfg_we             | cfg_index, cfg_wdata
//
// from acceptance to out_tvalid a word passes one sequencer state each for:
// divide-by-three extract, sector compare, turn update, position multiply, add.
// one word is in flight at a time; in_tready is high only while idle, so a new
// word is taken only after the previous one has left the last state.
// the output register holds a finished word while the next one is worked on;
// the last step waits while that register is still occupied.
// rst_n (synchronous) restores register defaults, zero turns and sector zero.
module multi_turn_angle_tracker #(
  parameter int ANGLE_BITS = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mtat_pkg::IN_DATA_W-1:0]     in_tdata,   // [15:0] raw_angle
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mtat_pkg::OUT_DATA_W-1:0]    out_tdata,  // [31:0] total_position, [47:32] turn_count
  input  logic                               cfg_we,
  input  logic [mtat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mtat_pkg::CFG_W-1:0]         cfg_wdata
);

  mtat_pkg::cmd_t                cmd;
  logic [mtat_pkg::POS_W-1:0]    total_position;
  logic [mtat_pkg::TCNT_W-1:0]   turn_count;

  mtat_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  mtat_dp #(
    .ANGLE_BITS (ANGLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .raw_angle      (in_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .total_position (total_position),
    .turn_count     (turn_count)
  );

  assign out_tdata = {turn_count, total_position};

endmodule
